FILE: sv/rmf_pkg.sv
// Shared types for the running median filter.
// No dependencies; every other file imports this package.
package rmf_pkg;

  localparam int SampleWidth = 32;

  typedef logic signed [SampleWidth-1:0] rmf_sample_t;

  // Per-cycle commands broadcast to every sorted cell.
  typedef struct packed {
    logic del;  // drop the evicted value, close the gap
    logic ins;  // open a slot and place the new sample
  } rmf_ctrl_t;

endpackage

FILE: sv/rmf_sample_if.sv
// Input stream channel: valid/ready with one sample per beat.
// Depends on rmf_pkg.
interface rmf_sample_if import rmf_pkg::*;;
  logic        valid;
  logic        ready;
  rmf_sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

FILE: sv/rmf_median_if.sv
// Output stream channel: valid/ready with one median per beat.
// Depends on rmf_pkg.
interface rmf_median_if import rmf_pkg::*;;
  logic        valid;
  logic        ready;
  rmf_sample_t median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

FILE: sv/running_median_filter_int_top.sv
// Top level of the running median filter: control, history line, sorted cells.
// Depends on rmf_pkg, rmf_sample_if, rmf_median_if, rmf_ring, rmf_cell.
//
// Usage:
//   in  : one signed 32-bit sample per beat (valid/ready).
//   out : one signed 32-bit median per beat, the element at WINDOW/2 of the
//         sorted window after the new sample is taken in.
// Timing:
//   The accept edge shifts the history line and removes the evicted value
//   from the sorted row in the same edge. Once out is free, the insert pass
//   places the new sample and loads the output register in the same edge.
//   A new sample is taken only after the insert pass of the last one: the row
//   of cells does at most one compare-and-shift pass per cycle, remove then insert.
// Reset (rst, synchronous): history line and sorted row clear to zero, so
//   the first WINDOW-1 medians include those zeros. in is not ready in reset.
// Stall: while out holds an untaken median, in takes at most one more
//   sample; its insert pass then waits and in stays not ready until out
//   frees up. Nothing is dropped.
module running_median_filter_int_top import rmf_pkg::*; #(
  parameter int WINDOW = 5
) (
  input  logic                clk,
  input  logic                rst,
  rmf_sample_if.sink          in,
  rmf_median_if.source        out
);

  localparam int Mid = WINDOW / 2;

  typedef enum logic {IDLE, INSERT} state_t;

  state_t      state;
  rmf_sample_t fresh;
  rmf_sample_t gone;
  rmf_ctrl_t   ctrl;
  logic        accept;
  logic        out_free;

  rmf_sample_t cell_value [WINDOW];
  rmf_sample_t cell_next  [WINDOW];
  logic        cell_gt    [WINDOW];

  assign in.ready = (state == IDLE) && !rst;
  assign accept   = in.valid && in.ready;
  assign out_free = !out.valid || out.ready;

  // delete pass rides the accept edge; insert waits for room at the output
  assign ctrl.del = accept;
  assign ctrl.ins = (state == INSERT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out.valid <= 1'b0;
    end else begin
      // a new median in the same edge keeps valid high
      if (out.valid && out.ready && !ctrl.ins) out.valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            fresh <= in.sample;
            state <= INSERT;
          end
        end
        INSERT: begin
          if (out_free) begin
            out.median <= cell_next[Mid];
            out.valid  <= 1'b1;
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  rmf_ring #(.WINDOW(WINDOW)) u_ring (
    .clk    (clk),
    .rst    (rst),
    .shift  (accept),
    .sample (in.sample),
    .oldest (gone)
  );

  // sorted row, ascending from cell 0
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    rmf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .gone       (gone),
      .fresh      (fresh),
      .tail       (k == WINDOW - 1),
      .prev_gt    ((k == 0) ? 1'b0 : cell_gt[(k == 0) ? 0 : k - 1]),
      .prev_value (cell_value[(k == 0) ? 0 : k - 1]),
      .next_value (cell_value[(k == WINDOW - 1) ? k : k + 1]),
      .value      (cell_value[k]),
      .value_next (cell_next[k]),
      .gt         (cell_gt[k])
    );
  end

endmodule

FILE: sv/rmf_ring.sv
// History shift line: newest sample enters at tap 0, oldest leaves at the end.
// Depends on rmf_pkg.
module rmf_ring import rmf_pkg::*; #(
  parameter int WINDOW = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        shift,
  input  rmf_sample_t sample,
  output rmf_sample_t oldest
);

  rmf_sample_t taps [WINDOW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WINDOW; k++) taps[k] <= '0;
    end else if (shift) begin
      taps[0] <= sample;
      for (int k = 1; k < WINDOW; k++) taps[k] <= taps[k-1];
    end
  end

  assign oldest = taps[WINDOW-1];

endmodule

FILE: sv/rmf_cell.sv
// One slot of the sorted window: compare against a broadcast operand and
// take a value from itself or a neighbor. Depends on rmf_pkg.
module rmf_cell import rmf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  rmf_ctrl_t   ctrl,
  input  rmf_sample_t gone,
  input  rmf_sample_t fresh,
  input  logic        tail,        // last cell: always counts as above fresh
  input  logic        prev_gt,
  input  rmf_sample_t prev_value,
  input  rmf_sample_t next_value,
  output rmf_sample_t value,
  output rmf_sample_t value_next,
  output logic        gt
);

  rmf_sample_t cmp_op;
  logic        lt;

  assign cmp_op = ctrl.del ? gone : fresh;
  assign lt     = value < cmp_op;
  assign gt     = tail | (value > cmp_op);

  always_comb begin
    value_next = value;
    if (ctrl.del) begin
      // cells at or past the first match pull from the right
      if (!lt) value_next = next_value;
    end else if (ctrl.ins) begin
      if (gt) value_next = prev_gt ? prev_value : fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else begin
      value <= value_next;
    end
  end

endmodule

FILE: test/rmf_median_checker.sv
// Median checker: watches both channels of the filter, predicts each median and compares.
// Depends on rmf_pkg; instantiated by tb_top beside the filter.
module rmf_median_checker import rmf_pkg::*; #(
  parameter int WINDOW = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  rmf_sample_t in_sample,
  input  logic        out_valid,
  input  logic        out_ready,
  input  rmf_sample_t out_median,
  output int          errors,
  output int          pending
);

  // Shadow window: history in arrival order and the same values kept sorted.
  rmf_sample_t history [WINDOW];
  rmf_sample_t ordered [WINDOW];
  int          slot;

  rmf_sample_t medians_due [$];
  int          fail_count = 0;
  int          due_count = 0;

  assign errors  = fail_count;
  assign pending = due_count;

  // Takes one sample into the shadow window and returns the new median.
  function automatic rmf_sample_t slide_window(input rmf_sample_t fresh);
    rmf_sample_t gone;
    int          hole;
    int          k;
    gone          = history[slot];
    history[slot] = fresh;
    slot          = (slot + 1) % WINDOW;
    // drop the lowest-index copy of the evicted value, or the top entry if absent
    hole = WINDOW - 1;
    for (k = 0; k < WINDOW; k++) begin
      if (ordered[k] == gone) begin
        hole = k;
        break;
      end
    end
    for (k = hole; k < WINDOW - 1; k++) ordered[k] = ordered[k + 1];
    // new value goes after any equal entries
    k = WINDOW - 2;
    while (k >= 0 && ordered[k] > fresh) begin
      ordered[k + 1] = ordered[k];
      k--;
    end
    ordered[k + 1] = fresh;
    return ordered[WINDOW / 2];
  endfunction

  always @(posedge clk) begin
    rmf_sample_t want;
    if (rst) begin
      for (int k = 0; k < WINDOW; k++) begin
        history[k] = '0;
        ordered[k] = '0;
      end
      slot = 0;
      medians_due.delete();
    end else begin
      // a median beat never belongs to a sample taken in the same edge
      if (out_valid && out_ready) begin
        if (medians_due.size() == 0) begin
          $error("median beat with nothing expected: got %0d", out_median);
          fail_count <= fail_count + 1;
        end else begin
          want = medians_due.pop_front();
          if (out_median !== want) begin
            $error("median mismatch: expected %0d, got %0d", want, out_median);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) medians_due.push_back(slide_window(in_sample));
    end
    due_count <= medians_due.size();
  end

endmodule

FILE: test/tb_top.sv
// Testbench top for running_median_filter_int_top: clock, reset, sample stimulus,
// random stalls on both channels and the verdict. Depends on rmf_pkg, both channel
// interfaces, the filter and rmf_median_checker.
module tb_top;
  import rmf_pkg::*;

  localparam int          WINDOW    = 5;
  localparam rmf_sample_t SampleMax = 32'sh7fff_ffff;
  localparam rmf_sample_t SampleMin = 32'sh8000_0000;
  localparam int          MaxWait   = 18;
  localparam int          RandItems = 950;

  // Directed opener: full-scale swings, sign boundaries, runs of duplicates
  // (so equal values get evicted), then a descending ramp. The first few medians
  // also cover the start-up zeros left by reset.
  localparam int DirectedLen = 22;
  localparam rmf_sample_t Directed [DirectedLen] = '{
    SampleMax, SampleMin, SampleMax, SampleMin, -32'sd1, 32'sd1, 32'sd0,
    32'sd5, 32'sd5, 32'sd5, 32'sd5, 32'sd5,
    32'sd3, 32'sd3, 32'sd7, 32'sd7, 32'sd3,
    32'sd40, 32'sd30, 32'sd20, 32'sd10, 32'sd0
  };

  logic clk;
  logic rst;

  rmf_sample_if in_ch ();
  rmf_median_if out_ch ();

  running_median_filter_int_top #(.WINDOW(WINDOW)) u_dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch)
  );

  int errors;
  int pending;

  rmf_median_checker #(.WINDOW(WINDOW)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_sample  (in_ch.sample),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_median (out_ch.median),
    .errors     (errors),
    .pending    (pending)
  );

  // Beat flags, registered at the rising edge and read at the falling edge,
  // so the driving processes never race the handshake.
  logic in_beat  = 1'b0;
  logic out_beat = 1'b0;

  always @(posedge clk) begin
    in_beat  <= in_ch.valid && in_ch.ready;
    out_beat <= out_ch.valid && out_ch.ready;
  end

  // Quiet mode: stretches where a side never idles (back-to-back beats).
  bit send_quiet = 1'b0;
  bit recv_quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop with a wide margin over the worst-case run.
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Mix of value classes: full 32-bit range for bit coverage, a narrow band
  // around zero so the window fills with duplicates, and the range extremes.
  function automatic rmf_sample_t pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return rmf_sample_t'($urandom);
      4, 5, 6:    return rmf_sample_t'($signed($urandom_range(0, 8)) - 4);
      7: begin
        case ($urandom_range(0, 5))
          0:       return SampleMax;
          1:       return SampleMin;
          2:       return SampleMax - 1;
          3:       return SampleMin + 1;
          4:       return -32'sd1;
          default: return 32'sd0;
        endcase
      end
      default:    return rmf_sample_t'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  // One sample beat: optional idle gap, then hold valid until the beat lands.
  // Valid only drops when a gap is drawn, so back-to-back beats keep it high.
  task automatic send_sample(input rmf_sample_t value);
    int gap;
    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, MaxWait);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= value;
    do @(negedge clk); while (!in_beat);
  endtask

  // Hold off the sender until every predicted median has come back.
  task automatic drain_medians();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Median sink: random stall before each beat, then ready until it is taken.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
      stall = recv_quiet ? 0 : $urandom_range(0, MaxWait);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(negedge clk); while (!out_beat);
    end
  end

  // Main sequence.
  initial begin
    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DirectedLen; i++) send_sample(Directed[i]);

    // Sender waits out the whole pipeline once before the random run.
    drain_medians();

    for (int i = 0; i < RandItems; i++) begin
      send_sample(pick_sample());
      if (i == RandItems / 2) drain_medians();
    end

    drain_medians();
    // leave margin for any stray beat
    repeat (10) @(negedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
